// File: hw/rtl/complex_mixer_fir_filter_core_assert.svh
// ----------------------------------------------------------------------------
// complex mixer fir filter assertion macros
// concurrent checks clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MIXER_FIR_FILTER_CORE_ASSERT_SVH
`define COMPLEX_MIXER_FIR_FILTER_CORE_ASSERT_SVH

// property that must hold at every edge out of reset
`define CMFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies expectation in the next
`define CMFF_ASSERT_NEXT(lbl, cond, expect_nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (expect_nxt)) else $error(msg);

`endif

// File: hw/rtl/cmff_pkg.sv
// ----------------------------------------------------------------------------
// cmff_pkg
// shared constants, opcodes, mixer table and rounding for the mixer fir core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmff_pkg;

  // filter geometry
  localparam int unsigned TAPS   = 101;
  localparam int unsigned ADDR_W = $clog2(TAPS);
  localparam int unsigned CNT_W  = $clog2(TAPS + 1);

  // mixer: 1500 Hz at 8 kHz is 3 steps of a 16-step circle
  localparam int unsigned PHASE_STEPS = 16;
  localparam int unsigned PHASE_W     = $clog2(PHASE_STEPS);
  localparam int unsigned MIX_STEP    = 3;
  localparam int unsigned SIN_OFS     = 3 * PHASE_STEPS / 4;

  // field and datapath widths
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned TAPIDX_W  = 7;
  localparam int unsigned TAP_CMP_W = 9;
  localparam int unsigned SAMP_W    = 16;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned DLY_W     = 2 * SAMP_W;
  localparam int unsigned PROD_W    = COEF_W + SAMP_W;
  localparam int unsigned ACC_W     = PROD_W + $clog2(TAPS);
  localparam int unsigned RND_W     = ACC_W + 1;

  localparam int unsigned MIX_SHIFT = 14;
  localparam int unsigned FIR_SHIFT = 17;

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);

  typedef enum logic [OPC_W-1:0] {
    OP_WR_COEF = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  // cos(2*pi*k/16) in q2.14
  function automatic logic signed [SAMP_W-1:0] cos_lut(input logic [PHASE_W-1:0] k);
    logic signed [SAMP_W-1:0] v;
    unique case (k)
      4'd0:    v = 16'sd16384;
      4'd1:    v = 16'sd15137;
      4'd2:    v = 16'sd11585;
      4'd3:    v = 16'sd6270;
      4'd4:    v = 16'sd0;
      4'd5:    v = -16'sd6270;
      4'd6:    v = -16'sd11585;
      4'd7:    v = -16'sd15137;
      4'd8:    v = -16'sd16384;
      4'd9:    v = -16'sd15137;
      4'd10:   v = -16'sd11585;
      4'd11:   v = -16'sd6270;
      4'd12:   v = 16'sd0;
      4'd13:   v = 16'sd6270;
      4'd14:   v = 16'sd11585;
      4'd15:   v = 16'sd15137;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // round half up by floor shift, then clamp to 16 bits
  function automatic logic signed [SAMP_W-1:0] round_sat(
    input logic signed [RND_W-1:0] x,
    input int unsigned             sh
  );
    logic signed [RND_W-1:0] bias;
    logic signed [RND_W-1:0] t;
    bias = RND_W'(1) << (sh - 1);
    t    = (x + bias) >>> sh;
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return SAMP_W'(t);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/complex_mixer_fir_filter_core.sv
// ----------------------------------------------------------------------------
// complex_mixer_fir_filter_core
// complex downmix by a 16-step phase table followed by a memory-based fir
// lowpass on i and q, with loadable q1.17 coefficients
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | opcode, tap_index, coeff_value,
//          |           |                         | in_i, in_q
//  out     | source    | out_valid_o/out_stall_i | out_i, out_q
//
//  a sample beat occupies the core through the mixer states, the tap walk and
//  the result state: one tap per cycle through the single read port of the delay
//  and coefficient memories, plus the read/multiply pipeline fill
//  coefficient, clear and no-op beats leave the core idle for the next beat
//  reset clears state at once through per-entry valid bits, no clearing pass
//  a finished result waits in the output register; the next beats are taken
//  meanwhile, and a later sample holds in its final cycle until it is free
//
`timescale 1ns / 1ps
`default_nettype none

`include "complex_mixer_fir_filter_core_assert.svh"

module complex_mixer_fir_filter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input beats
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic        [cmff_pkg::OPC_W-1:0]    opcode_i,
  input  wire logic        [cmff_pkg::TAPIDX_W-1:0] tap_index_i,
  input  wire logic signed [cmff_pkg::COEF_W-1:0]   coeff_value_i,
  input  wire logic signed [cmff_pkg::SAMP_W-1:0]   in_i_i,
  input  wire logic signed [cmff_pkg::SAMP_W-1:0]   in_q_i,
  // result beats
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [cmff_pkg::SAMP_W-1:0]   out_i_o,
  output logic signed      [cmff_pkg::SAMP_W-1:0]   out_q_o
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX0 = 3'd1;  // cos products
  localparam logic [2:0] ST_MIX1 = 3'd2;  // sin products
  localparam logic [2:0] ST_MIX2 = 3'd3;  // combine, round, write delay line
  localparam logic [2:0] ST_FIR  = 3'd4;  // tap walk
  localparam logic [2:0] ST_OUT  = 3'd5;  // round result into output register

  localparam int unsigned AW  = cmff_pkg::ADDR_W;
  localparam int unsigned SW  = cmff_pkg::SAMP_W;
  localparam int unsigned CW  = cmff_pkg::COEF_W;
  localparam int unsigned PW  = cmff_pkg::PROD_W;
  localparam int unsigned RW  = cmff_pkg::RND_W;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  logic [2:0]                      state_q, state_d;
  logic [AW-1:0]                   ptr_q, ptr_d;       // write pointer
  logic [cmff_pkg::PHASE_W-1:0]    phase_q, phase_d;   // mixer phase
  logic [AW-1:0]                   idx_q, idx_d;       // delay line read address
  logic [cmff_pkg::CNT_W-1:0]      cnt_q, cnt_d;       // tap counter
  logic                            rd_vld_q, rd_vld_d; // read data present
  logic                            mul_vld_q, mul_vld_d; // product present
  logic                            out_valid_q, out_valid_d;
  logic [cmff_pkg::TAPS-1:0]       dly_vld_q, dly_vld_d;
  logic [cmff_pkg::TAPS-1:0]       coef_vld_q, coef_vld_d;

  // payload registers
  logic signed [SW-1:0]            xi_q, xq_q;
  logic signed [PW-1:0]            prod_i_q, prod_q_q;
  logic signed [PW-1:0]            rot_i_q, rot_q_q;
  logic signed [cmff_pkg::ACC_W-1:0] acc_i_q, acc_q_q;
  logic signed [SW-1:0]            out_i_q, out_q_q;

  // memories and their registered read ports
  logic [cmff_pkg::DLY_W-1:0]      dly_mem [cmff_pkg::TAPS];
  logic [CW-1:0]                   coef_mem [cmff_pkg::TAPS];
  logic [cmff_pkg::DLY_W-1:0]      dly_rd_q;
  logic [CW-1:0]                   coef_rd_q;
  logic                            dly_hit_q, coef_hit_q;

  // --------------------------------------------------------------------------
  // input handshake and opcode decode
  // --------------------------------------------------------------------------
  logic                            in_acc;
  logic                            is_wr, is_sample, is_clear;
  logic [cmff_pkg::TAP_CMP_W-1:0]  tap_wide;
  logic                            tap_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    is_wr     = 1'b0;
    is_sample = 1'b0;
    is_clear  = 1'b0;
    unique case (opcode_i)
      cmff_pkg::OP_WR_COEF: is_wr     = in_acc;
      cmff_pkg::OP_SAMPLE:  is_sample = in_acc;
      cmff_pkg::OP_CLEAR:   is_clear  = in_acc;
      cmff_pkg::OP_NOP:     ;
      default:              ;
    endcase
  end

  // indexes of TAPS or more are dropped
  assign tap_wide = cmff_pkg::TAP_CMP_W'(tap_index_i);
  assign tap_ok   = tap_wide < cmff_pkg::TAP_CMP_W'(cmff_pkg::TAPS);

  // --------------------------------------------------------------------------
  // mixer table lookup: index is MIX_STEP * phase, sine a quarter turn back
  // --------------------------------------------------------------------------
  logic [cmff_pkg::PHASE_W-1:0]    cos_k, sin_k;
  logic signed [SW-1:0]            cos_v, sin_v;

  assign cos_k = cmff_pkg::PHASE_W'(phase_q * cmff_pkg::MIX_STEP);
  assign sin_k = cmff_pkg::PHASE_W'(cos_k + cmff_pkg::PHASE_W'(cmff_pkg::SIN_OFS));
  assign cos_v = cmff_pkg::cos_lut(cos_k);
  assign sin_v = cmff_pkg::cos_lut(sin_k);

  // --------------------------------------------------------------------------
  // shared multiplier pair: mixer products first, then one tap per cycle
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]            op_a;
  logic signed [SW-1:0]            op_bi, op_bq;
  logic signed [PW-1:0]            prod_i_d, prod_q_d;

  always_comb begin
    unique case (state_q)
      ST_MIX0: begin
        op_a  = CW'(cos_v);
        op_bi = xi_q;
        op_bq = xq_q;
      end
      ST_MIX1: begin
        op_a  = CW'(sin_v);
        op_bi = xq_q;
        op_bq = xi_q;
      end
      default: begin
        // unwritten coefficients and delay entries read as zero; clear drops only the delay ones
        op_a  = coef_hit_q ? $signed(coef_rd_q) : '0;
        op_bi = dly_hit_q ? $signed(dly_rd_q[SW-1:0]) : '0;
        op_bq = dly_hit_q ? $signed(dly_rd_q[cmff_pkg::DLY_W-1:SW]) : '0;
      end
    endcase
  end

  assign prod_i_d = op_a * op_bi;
  assign prod_q_d = op_a * op_bq;

  // ri = i*c + q*s, rq = q*c - i*s
  logic signed [RW-1:0]            rot_i_sum, rot_q_sum;
  logic signed [SW-1:0]            ri, rq;

  assign rot_i_sum = RW'(rot_i_q) + RW'(prod_i_q);
  assign rot_q_sum = RW'(rot_q_q) - RW'(prod_q_q);
  assign ri        = cmff_pkg::round_sat(rot_i_sum, cmff_pkg::MIX_SHIFT);
  assign rq        = cmff_pkg::round_sat(rot_q_sum, cmff_pkg::MIX_SHIFT);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic                            rd_en;
  logic                            dly_we;
  logic                            out_load;

  assign rd_en    = (state_q == ST_FIR) && (cnt_q < cmff_pkg::CNT_W'(cmff_pkg::TAPS));
  assign dly_we   = (state_q == ST_MIX2);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    dly_vld_d  = dly_vld_q;
    coef_vld_d = coef_vld_q;
    rd_vld_d   = rd_en;
    mul_vld_d  = rd_vld_q;

    unique case (state_q)
      ST_IDLE: begin
        if (is_sample) begin
          state_d = ST_MIX0;
        end
        if (is_clear) begin
          dly_vld_d = '0;
          ptr_d     = '0;
        end
        if (is_wr && tap_ok) begin
          coef_vld_d[tap_wide[AW-1:0]] = 1'b1;
        end
      end
      ST_MIX0: state_d = ST_MIX1;
      ST_MIX1: state_d = ST_MIX2;
      ST_MIX2: begin
        // newest sample lands at the pointer, walk starts there
        dly_vld_d[ptr_q] = 1'b1;
        idx_d   = ptr_q;
        cnt_d   = '0;
        state_d = ST_FIR;
      end
      ST_FIR: begin
        if (rd_en) begin
          cnt_d = cnt_q + 1'b1;
          idx_d = (idx_q == '0) ? AW'(cmff_pkg::TAPS - 1) : idx_q - 1'b1;
        end else if (!rd_vld_q) begin
          // last product adds in on this edge
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          ptr_d   = (ptr_q == AW'(cmff_pkg::TAPS - 1)) ? '0 : ptr_q + 1'b1;
          phase_d = phase_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      phase_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dly_vld_q   <= '0;
      coef_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      mul_vld_q   <= mul_vld_d;
      out_valid_q <= out_valid_d;
      dly_vld_q   <= dly_vld_d;
      coef_vld_q  <= coef_vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      xi_q <= in_i_i;
      xq_q <= in_q_i;
    end
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    // cos products are parked while the sin products form
    if (state_q == ST_MIX1) begin
      rot_i_q <= prod_i_q;
      rot_q_q <= prod_q_q;
    end
    if (state_q == ST_MIX2) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (mul_vld_q) begin
      acc_i_q <= acc_i_q + cmff_pkg::ACC_W'(prod_i_q);
      acc_q_q <= acc_q_q + cmff_pkg::ACC_W'(prod_q_q);
    end
    if (out_load) begin
      out_i_q <= cmff_pkg::round_sat(RW'(acc_i_q), cmff_pkg::FIR_SHIFT);
      out_q_q <= cmff_pkg::round_sat(RW'(acc_q_q), cmff_pkg::FIR_SHIFT);
    end
  end

  // --------------------------------------------------------------------------
  // memories: one write and one registered read each
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[ptr_q] <= {rq, ri};
    end
    if (rd_en) begin
      dly_rd_q  <= dly_mem[idx_q];
      dly_hit_q <= dly_vld_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_wr && tap_ok) begin
      coef_mem[tap_wide[AW-1:0]] <= coeff_value_i;
    end
    if (rd_en) begin
      coef_rd_q  <= coef_mem[cnt_q[AW-1:0]];
      coef_hit_q <= coef_vld_q[cnt_q[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CMFF_ASSERT(a_ptr_range,
    {1'b0, ptr_q} < (AW + 1)'(cmff_pkg::TAPS), "write pointer beyond tap count")
  `CMFF_ASSERT(a_cnt_range,
    cnt_q <= cmff_pkg::CNT_W'(cmff_pkg::TAPS), "tap counter overran")
  `CMFF_ASSERT(a_mul_in_fir,
    !mul_vld_q || state_q == ST_FIR, "product pending outside the tap walk")
  `CMFF_ASSERT(a_out_after_walk,
    state_q != ST_OUT || (cnt_q == cmff_pkg::CNT_W'(cmff_pkg::TAPS) && !rd_vld_q),
    "result stage entered before all taps were read")
  `CMFF_ASSERT_NEXT(a_out_only_from_seq,
    !out_valid_q && state_q != ST_OUT, !out_valid_q,
    "result appeared without a finished sample")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: complex mixer fir filter core testbench
// drives coefficient, sample, clear and no-op beats with bursty valid and a
// patterned output stall, predicts every i/q result in step with the beats
// taken, and compares each result beat field by field in arrival order
// ----------------------------------------------------------------------------

module tb;

  localparam int COEF_MAX = 131071;
  localparam int COEF_MIN = -131072;
  localparam int SAMP_MAX = 32767;
  localparam int SAMP_MIN = -32768;

  // one input beat, with an optional hand-typed result for directed rows
  typedef struct {
    cmff_pkg::opcode_e                    op;
    logic [cmff_pkg::TAPIDX_W-1:0]        tap;
    logic signed [cmff_pkg::COEF_W-1:0]   coef;
    logic signed [cmff_pkg::SAMP_W-1:0]   si;
    logic signed [cmff_pkg::SAMP_W-1:0]   sq;
    bit                                   typed;
    logic signed [cmff_pkg::SAMP_W-1:0]   want_i;
    logic signed [cmff_pkg::SAMP_W-1:0]   want_q;
  } beat_t;

  typedef struct {
    logic signed [cmff_pkg::SAMP_W-1:0] i;
    logic signed [cmff_pkg::SAMP_W-1:0] q;
  } iq_t;

  // receiver stall modes
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_e;

  logic                                 clk = 1'b0;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [cmff_pkg::OPC_W-1:0]           opcode_i;
  logic [cmff_pkg::TAPIDX_W-1:0]        tap_index_i;
  logic signed [cmff_pkg::COEF_W-1:0]   coeff_value_i;
  logic signed [cmff_pkg::SAMP_W-1:0]   in_i_i;
  logic signed [cmff_pkg::SAMP_W-1:0]   in_q_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [cmff_pkg::SAMP_W-1:0]   out_i_o;
  logic signed [cmff_pkg::SAMP_W-1:0]   out_q_o;

  // predicted filter state
  logic signed [cmff_pkg::COEF_W-1:0]   coef_mem [cmff_pkg::TAPS];
  logic signed [cmff_pkg::SAMP_W-1:0]   line_i   [cmff_pkg::TAPS];
  logic signed [cmff_pkg::SAMP_W-1:0]   line_q   [cmff_pkg::TAPS];
  int unsigned                          wr_ptr;
  int unsigned                          mix_phase;

  iq_t                        expected_iq [$];
  beat_t                      directed_rows [$];

  int unsigned burst_left = 0;
  rx_mode_e    stall_mode = RX_OPEN;
  int unsigned stall_left = 0;

  int n_samples      = 0;
  int n_coef_writes  = 0;
  int n_coef_ignored = 0;
  int n_clears       = 0;
  int n_nops         = 0;
  int n_checked      = 0;
  int n_errors       = 0;

  complex_mixer_fir_filter_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .tap_index_i  (tap_index_i),
    .coeff_value_i(coeff_value_i),
    .in_i_i       (in_i_i),
    .in_q_i       (in_q_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o)
  );

  always #1 clk = ~clk;

  // cos(2*pi*k/16) in q2.14, folded onto the first quadrant
  function automatic int cos_q14(input int unsigned k);
    int unsigned m;
    bit          neg;
    int          mag;
    m   = k % cmff_pkg::PHASE_STEPS;
    neg = (m > 4) && (m < 12);
    if (m > 8) begin
      m = cmff_pkg::PHASE_STEPS - m;
    end
    if (m > 4) begin
      m = 8 - m;
    end
    case (m)
      0:       mag = 16384;
      1:       mag = 15137;
      2:       mag = 11585;
      3:       mag = 6270;
      default: mag = 0;
    endcase
    return neg ? -mag : mag;
  endfunction

  // floor-shift rounding with half added, clipped to 16 bits
  function automatic logic signed [cmff_pkg::SAMP_W-1:0] round_clip16(input longint x,
                                                                      input int sh);
    longint r;
    r = (x + (longint'(1) << (sh - 1))) >>> sh;
    if (r > SAMP_MAX) begin
      r = SAMP_MAX;
    end else if (r < SAMP_MIN) begin
      r = SAMP_MIN;
    end
    return r[cmff_pkg::SAMP_W-1:0];
  endfunction

  function automatic beat_t mk_beat(input cmff_pkg::opcode_e op, input int tap,
                                    input int coef, input int si, input int sq);
    beat_t b;
    b.op     = op;
    b.tap    = cmff_pkg::TAPIDX_W'(tap);
    b.coef   = cmff_pkg::COEF_W'(coef);
    b.si     = cmff_pkg::SAMP_W'(si);
    b.sq     = cmff_pkg::SAMP_W'(sq);
    b.typed  = 1'b0;
    b.want_i = '0;
    b.want_q = '0;
    return b;
  endfunction

  function automatic beat_t mk_typed(input int si, input int sq, input int wi, input int wq);
    beat_t b;
    b        = mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, si, sq);
    b.typed  = 1'b1;
    b.want_i = cmff_pkg::SAMP_W'(wi);
    b.want_q = cmff_pkg::SAMP_W'(wq);
    return b;
  endfunction

  // coefficient draw for one of four gain profiles
  function automatic int coef_for_profile(input int unsigned profile);
    int mag;
    case (profile)
      0: begin
        mag = COEF_MAX >> $urandom_range(4, 9);
        return $urandom_range(0, 2 * mag) - mag;
      end
      1: return ($urandom_range(0, 7) == 0) ?
                int'($signed(cmff_pkg::COEF_W'($urandom))) : 0;
      2: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      default: begin
        mag = COEF_MAX >> $urandom_range(2, 5);
        return $urandom_range(0, 2 * mag) - mag;
      end
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMP_MIN;
          1:       return SAMP_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      1:       return $urandom_range(0, 128) - 64;
      default: return int'($signed(cmff_pkg::SAMP_W'($urandom)));
    endcase
  endfunction

  // downmix, fir and state advance for one accepted beat
  task automatic mix_filter_predict(input beat_t b);
    int unsigned k;
    int unsigned ks;
    int unsigned idx;
    longint      c;
    longint      s;
    longint      xi;
    longint      xq;
    longint      acc_i;
    longint      acc_q;
    iq_t         res;
    case (b.op)
      cmff_pkg::OP_WR_COEF: begin
        if (b.tap < cmff_pkg::TAPS) begin
          coef_mem[b.tap] = b.coef;
          n_coef_writes++;
        end else begin
          n_coef_ignored++;
        end
      end
      cmff_pkg::OP_CLEAR: begin
        // coefficients and mixer phase survive a clear
        for (int n = 0; n < cmff_pkg::TAPS; n++) begin
          line_i[n] = '0;
          line_q[n] = '0;
        end
        wr_ptr = 0;
        n_clears++;
      end
      cmff_pkg::OP_SAMPLE: begin
        k  = (cmff_pkg::MIX_STEP * mix_phase) % cmff_pkg::PHASE_STEPS;
        ks = (k + cmff_pkg::PHASE_STEPS - cmff_pkg::PHASE_STEPS / 4) % cmff_pkg::PHASE_STEPS;
        c  = cos_q14(k);
        s  = cos_q14(ks);
        xi = b.si;
        xq = b.sq;
        // new rotated sample lands at the pointer before the sum is formed
        line_i[wr_ptr] = round_clip16(xi * c + xq * s, cmff_pkg::MIX_SHIFT);
        line_q[wr_ptr] = round_clip16(xq * c - xi * s, cmff_pkg::MIX_SHIFT);
        acc_i = 0;
        acc_q = 0;
        for (int n = 0; n < cmff_pkg::TAPS; n++) begin
          idx   = (wr_ptr + cmff_pkg::TAPS - n) % cmff_pkg::TAPS;
          acc_i += longint'(coef_mem[n]) * longint'(line_i[idx]);
          acc_q += longint'(coef_mem[n]) * longint'(line_q[idx]);
        end
        res.i = round_clip16(acc_i, cmff_pkg::FIR_SHIFT);
        res.q = round_clip16(acc_q, cmff_pkg::FIR_SHIFT);
        if (b.typed) begin
          res.i = b.want_i;
          res.q = b.want_q;
        end
        expected_iq.push_back(res);
        wr_ptr    = (wr_ptr + 1) % cmff_pkg::TAPS;
        mix_phase = (mix_phase + 1) % cmff_pkg::PHASE_STEPS;
        n_samples++;
      end
      default: n_nops++;
    endcase
  endtask

  // sender: bursts of random length, idle gaps with junk payload in between
  task automatic drive_beat(input beat_t b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_valid_i    = 1'b0;
      opcode_i      = cmff_pkg::OPC_W'($urandom);
      tap_index_i   = cmff_pkg::TAPIDX_W'($urandom);
      coeff_value_i = cmff_pkg::COEF_W'($urandom);
      in_i_i        = cmff_pkg::SAMP_W'($urandom);
      in_q_i        = cmff_pkg::SAMP_W'($urandom);
    end
    @(negedge clk);
    in_valid_i    = 1'b1;
    opcode_i      = b.op;
    tap_index_i   = b.tap;
    coeff_value_i = b.coef;
    in_i_i        = b.si;
    in_q_i        = b.sq;
    do @(posedge clk); while (in_stall_o);
    mix_filter_predict(b);
  endtask

  // drop valid and let every outstanding result beat come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid_i = 1'b0;
    wait (expected_iq.size() == 0);
  endtask

  // receiver: stall pattern changes to a random mode after each random-length run
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 120) : $urandom_range(20, 400);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= 1'b1;
    endcase
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    iq_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_iq.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected, got i=%0d q=%0d",
                 $time, out_i_o, out_q_o);
      end else begin
        want = expected_iq.pop_front();
        n_checked++;
        if (out_i_o !== want.i) begin
          n_errors++;
          $display("%0t: out_i mismatch, expected %0d, got %0d", $time, want.i, out_i_o);
        end
        if (out_q_o !== want.q) begin
          n_errors++;
          $display("%0t: out_q mismatch, expected %0d, got %0d", $time, want.q, out_q_o);
        end
      end
    end
  end

  initial begin
    int unsigned profile;
    int unsigned nwr;
    int unsigned ns;
    bit          first_set;
    bit          paused;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = cmff_pkg::OP_NOP;
    tap_index_i   = '0;
    coeff_value_i = '0;
    in_i_i        = '0;
    in_q_i        = '0;
    for (int n = 0; n < cmff_pkg::TAPS; n++) begin
      coef_mem[n] = '0;
      line_i[n]   = '0;
      line_q[n]   = '0;
    end
    wr_ptr    = 0;
    mix_phase = 0;

    // directed rows
    // all coefficients are zero out of reset, so the first sample gives zero
    directed_rows.push_back(mk_typed(SAMP_MAX, SAMP_MIN, 0, 0));
    // clear with junk in the unused fields
    directed_rows.push_back(mk_beat(cmff_pkg::OP_CLEAR, 99, -5, 1234, -4321));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, 0, COEF_MIN, SAMP_MAX, SAMP_MIN));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, cmff_pkg::TAPS - 1, COEF_MAX, 0, 0));
    // tap index at or past the filter length is dropped
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, cmff_pkg::TAPS, 77, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, 127, -1, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_NOP, 127, COEF_MAX, SAMP_MIN, SAMP_MAX));
    // phase 1, -1.0 at tap 0: i rotates past full scale and clips, the
    // product -1 * -1 clips high, q comes out negated
    directed_rows.push_back(mk_typed(SAMP_MIN, SAMP_MIN, SAMP_MAX, -17734));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, SAMP_MAX, SAMP_MAX));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, 1, 65536, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, 50, -65537, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 5, 9, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, -1, 1));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, 1, -1));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, SAMP_MIN, SAMP_MAX));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_CLEAR, 0, 0, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, 12345, -23456));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_WR_COEF, 0, 0, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_NOP, 0, 0, 0, 0));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 64, COEF_MIN, SAMP_MAX, SAMP_MIN));
    directed_rows.push_back(mk_beat(cmff_pkg::OP_SAMPLE, 0, 0, SAMP_MIN, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      drive_beat(directed_rows[r]);
    end
    hold_until_drained();

    // random part: each segment loads a coefficient set, maybe clears, then
    // streams samples with a few stray beats mixed in
    first_set = 1'b1;
    paused    = 1'b0;
    while (n_samples + n_coef_writes + n_clears < 1300) begin
      profile = $urandom_range(0, 3);
      nwr = (first_set || $urandom_range(0, 5) == 0) ? cmff_pkg::TAPS : $urandom_range(3, 25);
      first_set = 1'b0;
      for (int j = 0; j < nwr; j++) begin
        drive_beat(mk_beat(cmff_pkg::OP_WR_COEF,
                           (nwr == cmff_pkg::TAPS) ? j : $urandom_range(0, cmff_pkg::TAPS - 1),
                           coef_for_profile(profile), $urandom, $urandom));
      end
      if ($urandom_range(0, 1) == 1) begin
        drive_beat(mk_beat(cmff_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
      end
      // some runs are long enough to wrap the delay line pointer
      ns = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 230) : $urandom_range(8, 90);
      for (int j = 0; j < ns; j++) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 3))
            0: drive_beat(mk_beat(cmff_pkg::OP_NOP, $urandom, $urandom, $urandom, $urandom));
            1: drive_beat(mk_beat(cmff_pkg::OP_WR_COEF, $urandom_range(cmff_pkg::TAPS, 127),
                                  $urandom, $urandom, $urandom));
            2: drive_beat(mk_beat(cmff_pkg::OP_WR_COEF,
                                  $urandom_range(0, cmff_pkg::TAPS - 1),
                                  coef_for_profile(profile), $urandom, $urandom));
            default: drive_beat(mk_beat(cmff_pkg::OP_CLEAR, $urandom, $urandom, $urandom,
                                        $urandom));
          endcase
        end
        drive_beat(mk_beat(cmff_pkg::OP_SAMPLE, $urandom, $urandom, pick_sample(),
                           pick_sample()));
        // one hold-off in mid run until the result stream is empty
        if (!paused && n_samples + n_coef_writes + n_clears >= 650) begin
          hold_until_drained();
          paused = 1'b1;
        end
      end
    end

    hold_until_drained();
    repeat (3 * cmff_pkg::TAPS) @(posedge clk);
    $display("covered %0d samples, %0d coefficient writes, %0d dropped writes,",
             n_samples, n_coef_writes, n_coef_ignored);
    $display("%0d clears, %0d no-ops; compared %0d result beats, %0d errors",
             n_clears, n_nops, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3000000;
    $display("timeout with %0d result beats outstanding", expected_iq.size());
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cmff_pkg.sv
hw/rtl/complex_mixer_fir_filter_core.sv
tb/tb.sv
